### rtl/pcrm_pkg.sv
// Package for the PRS comb resource-element mapper.
// Holds register indexes, comb tables and fixed widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcrm_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_COMB_CODE    = 3'd0,
    REG_RE_OFFSET    = 3'd1,
    REG_NUM_RB       = 3'd2,
    REG_START_SYMBOL = 3'd3,
    REG_NUM_SYMBOLS  = 3'd4,
    REG_SSB_START    = 3'd5,
    REG_FFT_SIZE     = 3'd6,
    REG_AMPLITUDE    = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned PosW     = 13;  // subcarrier position arithmetic
  localparam int unsigned ElemW    = 12;  // holds up to 6 * 511 elements

  // QPSK component level, 1/sqrt(2) in Q15
  localparam logic [14:0] QPSK_LEVEL = 15'd23170;

  // Comb codes
  localparam logic [1:0] COMB_2  = 2'd0;
  localparam logic [1:0] COMB_4  = 2'd1;
  localparam logic [1:0] COMB_6  = 2'd2;
  localparam logic [1:0] COMB_12 = 2'd3;

  // Per-symbol subcarrier shift, row by comb code, column by symbol in occasion
  localparam logic [3:0] COMB_SHIFT [4][12] = '{
    '{4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1},
    '{4'd0, 4'd2, 4'd1, 4'd3, 4'd0, 4'd2, 4'd1, 4'd3, 4'd0, 4'd2, 4'd1, 4'd3},
    '{4'd0, 4'd3, 4'd1, 4'd4, 4'd2, 4'd5, 4'd0, 4'd3, 4'd1, 4'd4, 4'd2, 4'd5},
    '{4'd0, 4'd6, 4'd3, 4'd9, 4'd1, 4'd7, 4'd4, 4'd10, 4'd2, 4'd8, 4'd5, 4'd11}
  };

  // Comb size per code
  function automatic logic [3:0] comb_size(logic [1:0] code);
    logic [3:0] sz;
    unique case (code)
      COMB_2:  sz = 4'd2;
      COMB_4:  sz = 4'd4;
      COMB_6:  sz = 4'd6;
      default: sz = 4'd12;
    endcase
    return sz;
  endfunction

  // Elements per resource block (12 / comb)
  function automatic logic [2:0] elems_per_rb(logic [1:0] code);
    logic [2:0] n;
    unique case (code)
      COMB_2:  n = 3'd6;
      COMB_4:  n = 3'd3;
      COMB_6:  n = 3'd2;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  // val mod comb for val < 27: masks for powers of two, else up to four subtracts
  function automatic logic [3:0] comb_mod(logic [4:0] val, logic [1:0] code);
    logic [4:0] r;
    logic [4:0] sz;
    r  = val;
    sz = {1'b0, comb_size(code)};
    unique case (code)
      COMB_2: r = {4'd0, val[0]};
      COMB_4: r = {3'd0, val[1:0]};
      default: begin
        for (int s = 0; s < 4; s++) begin
          if (r >= sz) r = r - sz;
        end
      end
    endcase
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

### rtl/prs_comb_resource_mapper_unit.sv
// PRS comb resource-element mapper, top level.
// Depends on pcrm_pkg (tables, register indexes, widths).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / seq_bits_i) takes one QPSK
//   symbol per beat as two sign bits. Output channel (out_valid_o /
//   out_stall_i / result fields) gives one resource element per input beat:
//   OFDM symbol, subcarrier, flat grid index, scaled I/Q and an end-of-
//   occasion flag. Configuration is a write-only port (cfg_we_i, cfg_idx_i,
//   cfg_data_i), written while no beat is in flight.
//   The first register stage holds the sign bits and the element position
//   taken from the position counters, the second holds the flat index and
//   the scaled I/Q. Throughput is one beat per cycle unless the receiver
//   stalls; the position counters advance at each accepted beat.
//   Reset clears both stages and the counters and loads the register
//   defaults (comb 2, 24 RBs, one symbol, fft size 2048, full amplitude).
//   When the receiver stalls, the output holds; the first stage still takes
//   one more beat, and in_stall_o rises only once both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module prs_comb_resource_mapper_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [pcrm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [pcrm_pkg::CfgDataW-1:0]       cfg_data_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          seq_bits_i,
  // output channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [4:0]                               symbol_index_o,
  output logic [11:0]                              subcarrier_o,
  output logic [16:0]                              flat_index_o,
  output logic signed [15:0]                       i_value_o,
  output logic signed [15:0]                       q_value_o,
  output logic                                     last_o
);

  localparam int unsigned PosW  = pcrm_pkg::PosW;
  localparam int unsigned ElemW = pcrm_pkg::ElemW;

  // Configuration registers
  logic [1:0]  comb_code_q;
  logic [3:0]  re_offset_q;
  logic [8:0]  num_rb_q;
  logic [3:0]  start_symbol_q;
  logic [3:0]  num_symbols_q;
  logic [11:0] ssb_start_q;
  logic [12:0] fft_size_q;
  logic [14:0] amplitude_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comb_code_q    <= 2'd0;
      re_offset_q    <= 4'd0;
      num_rb_q       <= 9'd24;
      start_symbol_q <= 4'd0;
      num_symbols_q  <= 4'd1;
      ssb_start_q    <= 12'd0;
      fft_size_q     <= 13'd2048;
      amplitude_q    <= 15'd32767;
    end else if (cfg_we_i) begin
      unique case (pcrm_pkg::cfg_reg_e'(cfg_idx_i))
        pcrm_pkg::REG_COMB_CODE:    comb_code_q    <= cfg_data_i[1:0];
        pcrm_pkg::REG_RE_OFFSET:    re_offset_q    <= cfg_data_i[3:0];
        pcrm_pkg::REG_NUM_RB:       num_rb_q       <= cfg_data_i[8:0];
        pcrm_pkg::REG_START_SYMBOL: start_symbol_q <= cfg_data_i[3:0];
        pcrm_pkg::REG_NUM_SYMBOLS:  num_symbols_q  <= cfg_data_i[3:0];
        pcrm_pkg::REG_SSB_START:    ssb_start_q    <= cfg_data_i[11:0];
        pcrm_pkg::REG_FFT_SIZE:     fft_size_q     <= cfg_data_i[12:0];
        pcrm_pkg::REG_AMPLITUDE:    amplitude_q    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic a_vld_q, b_free, a_adv, in_acc;

  assign b_free     = !out_valid_o || !out_stall_i;
  assign a_adv      = a_vld_q && b_free;
  assign in_stall_o = a_vld_q && !b_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Position counters
  logic [3:0]       sym_cnt_q, sym_cnt_d;
  logic [ElemW-1:0] elem_cnt_q, elem_cnt_d;
  logic [PosW-1:0]  cur_sc_q, cur_sc_d;

  logic [3:0]       shift_row;
  logic [4:0]       off_sum;
  logic [PosW-1:0]  first_pos, k_pos;
  logic [PosW:0]    nxt_sum;
  logic [ElemW-1:0] per_sym;
  logic [8:0]       rb_eff;
  logic [3:0]       nsym_eff;
  logic [4:0]       sym_idx;
  logic             elem_wrap, occ_end;

  always_comb begin
    // first subcarrier of the current symbol
    shift_row = (sym_cnt_q >= 4'd12) ? sym_cnt_q - 4'd12 : sym_cnt_q;
    off_sum   = {1'b0, re_offset_q} + {1'b0, pcrm_pkg::COMB_SHIFT[comb_code_q][shift_row]};
    first_pos = {9'd0, pcrm_pkg::comb_mod(off_sum, comb_code_q)} + {1'b0, ssb_start_q};
    k_pos     = (elem_cnt_q == '0) ? first_pos : cur_sc_q;
    sym_idx   = {1'b0, start_symbol_q} + {1'b0, sym_cnt_q};

    // step along the comb, single wrap at the symbol size
    nxt_sum = {1'b0, k_pos} + {10'd0, pcrm_pkg::comb_size(comb_code_q)};
    if (nxt_sum >= {1'b0, fft_size_q}) nxt_sum = nxt_sum - {1'b0, fft_size_q};
    cur_sc_d = nxt_sum[PosW-1:0];

    // end of symbol / end of occasion
    rb_eff    = (num_rb_q == '0) ? 9'd1 : num_rb_q;
    nsym_eff  = (num_symbols_q == '0) ? 4'd1 : num_symbols_q;
    per_sym   = ElemW'({9'd0, pcrm_pkg::elems_per_rb(comb_code_q)} * {3'd0, rb_eff});
    elem_wrap = ({1'b0, elem_cnt_q} + 13'd1) >= {1'b0, per_sym};
    occ_end   = elem_wrap && (({1'b0, sym_cnt_q} + 5'd1) >= {1'b0, nsym_eff});

    elem_cnt_d = elem_wrap ? '0 : elem_cnt_q + ElemW'(1);
    if (!elem_wrap)   sym_cnt_d = sym_cnt_q;
    else if (occ_end) sym_cnt_d = 4'd0;
    else              sym_cnt_d = sym_cnt_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_cnt_q  <= '0;
      elem_cnt_q <= '0;
      cur_sc_q   <= '0;
    end else if (in_acc) begin
      sym_cnt_q  <= sym_cnt_d;
      elem_cnt_q <= elem_cnt_d;
      cur_sc_q   <= cur_sc_d;
    end
  end

  // Stage A: sign bits and element position
  logic [1:0]      a_bits_q;
  logic [4:0]      a_sym_q;
  logic [PosW-1:0] a_k_q;
  logic            a_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_acc) begin
      a_vld_q <= 1'b1;
    end else if (a_adv) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_bits_q <= seq_bits_i;
      a_sym_q  <= sym_idx;
      a_k_q    <= k_pos;
      a_last_q <= occ_end;
    end
  end

  // Stage B math: flat index and QPSK scaling
  logic [17:0] sym_x_fft;
  logic [18:0] flat_sum;
  logic [29:0] mag;
  logic [30:0] mag_rnd;
  logic [15:0] pos_val, neg_val;

  always_comb begin
    sym_x_fft = {13'd0, a_sym_q} * {5'd0, fft_size_q};
    flat_sum  = {1'b0, sym_x_fft} + {6'd0, a_k_q};
    mag       = {15'd0, amplitude_q} * {15'd0, pcrm_pkg::QPSK_LEVEL};
    mag_rnd   = {1'b0, mag} + 31'd32767;
    pos_val   = {1'b0, mag[29:15]};
    neg_val   = 16'd0 - mag_rnd[30:15];
  end

  // Stage B: result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (a_adv) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      symbol_index_o <= a_sym_q;
      subcarrier_o   <= a_k_q[11:0];
      flat_index_o   <= flat_sum[16:0];
      i_value_o      <= a_bits_q[0] ? neg_val : pos_val;
      q_value_o      <= a_bits_q[1] ? neg_val : pos_val;
      last_o         <= a_last_q;
    end
  end

endmodule

`default_nettype wire

### rtl/pcrm_checker.sv
// Port-level checker for the PRS comb resource-element mapper.
// Attached to prs_comb_resource_mapper_unit by the bind at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module pcrm_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [4:0]         symbol_index_o,
  input wire logic [16:0]        flat_index_o,
  input wire logic signed [15:0] i_value_o,
  input wire logic signed [15:0] q_value_o,
  input wire logic               last_o
);

  logic signed [16:0] iq_sum;
  assign iq_sum = {i_value_o[15], i_value_o} + {q_value_o[15], q_value_o};

  // A held result keeps its valid, flat index, symbol index and last flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(flat_index_o)
      && $stable(symbol_index_o) && $stable(last_o))
    else $error("stalled output beat changed");

  // Input backpressure only once the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output stage free");

  // Both components share one magnitude up to floor/ceil rounding
  a_iq_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (i_value_o == q_value_o) || (iq_sum == 17'sd0) || (iq_sum == -17'sd1))
    else $error("I and Q magnitudes disagree");

  // The scaled I value stays within the QPSK level
  a_iq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (i_value_o <= 16'sd23170) && (i_value_o >= -16'sd23170))
    else $error("I value out of range");

endmodule

bind prs_comb_resource_mapper_unit pcrm_checker u_pcrm_checker (.*);

`default_nettype wire

### verif/prs_comb_resource_mapper_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for prs_comb_resource_mapper_unit: a queue-fed driver,
// a clocked monitor and an in-bench predictor of every resource element.
// Depends on pcrm_pkg and the mapper RTL only.

module prs_comb_resource_mapper_unit_test;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned MaxPrinted = 40;

  // Per-symbol comb rotation, row by comb code
  localparam int unsigned COMB_ROTATION [4][12] = '{
    '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1},
    '{0, 2, 1, 3, 0, 2, 1, 3, 0, 2, 1, 3},
    '{0, 3, 1, 4, 2, 5, 0, 3, 1, 4, 2, 5},
    '{0, 6, 3, 9, 1, 7, 4, 10, 2, 8, 5, 11}
  };

  typedef struct {
    logic [1:0]  comb_code;
    logic [3:0]  re_offset;
    logic [8:0]  num_rb;
    logic [3:0]  start_symbol;
    logic [3:0]  num_symbols;
    logic [11:0] ssb_start;
    logic [12:0] fft_size;
    logic [14:0] amplitude;
  } map_cfg_t;

  typedef struct {
    logic [4:0]         symbol_index;
    logic [11:0]        subcarrier;
    logic [16:0]        flat_index;
    logic signed [15:0] i_value;
    logic signed [15:0] q_value;
    logic               last;
  } re_elem_t;

  // Block inputs, all known from time zero
  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic [2:0]  cfg_idx_i  = '0;
  logic [14:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic [1:0]  seq_bits_i = '0;
  logic        out_stall_i = 1'b0;

  // Block outputs
  logic               in_stall_o;
  logic               out_valid_o;
  logic [4:0]         symbol_index_o;
  logic [11:0]        subcarrier_o;
  logic [16:0]        flat_index_o;
  logic signed [15:0] i_value_o;
  logic signed [15:0] q_value_o;
  logic               last_o;

  // Predictor state and register copy
  map_cfg_t    cfg_mirror;
  logic [3:0]  occ_symbol;
  int unsigned sym_elem;
  logic [12:0] next_sc;

  re_elem_t    expected_elems[$];
  logic [1:0]  pending_bits[$];
  re_elem_t    want;
  int unsigned err_count = 0;
  int unsigned rx_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  prs_comb_resource_mapper_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .seq_bits_i     (seq_bits_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_index_o (symbol_index_o),
    .subcarrier_o   (subcarrier_o),
    .flat_index_o   (flat_index_o),
    .i_value_o      (i_value_o),
    .q_value_o      (q_value_o),
    .last_o         (last_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_error(string msg);
    err_count++;
    if (err_count <= MaxPrinted) $display("%0t ERROR %s", $time, msg);
  endtask

  // Mostly short pauses, a few long ones
  function automatic int unsigned pick_pause(bit enable);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enable || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic int unsigned comb_span(logic [1:0] code);
    case (code)
      pcrm_pkg::COMB_2:  return 2;
      pcrm_pkg::COMB_4:  return 4;
      pcrm_pkg::COMB_6:  return 6;
      default: return 12;
    endcase
  endfunction

  // (amplitude * +-level) >> 15, floor rounding
  function automatic logic signed [15:0] qpsk_scale(logic negative);
    int unsigned mag;
    int unsigned r;
    mag = cfg_mirror.amplitude;
    mag = mag * pcrm_pkg::QPSK_LEVEL;
    if (negative) r = 0 - ((mag + 32767) >> 15);
    else r = mag >> 15;
    return r[15:0];
  endfunction

  // Next resource element for one accepted QPSK beat
  task automatic predict_element(logic [1:0] bits);
    int unsigned span, rbs, nsym, per_symbol, k, sym, nxt, flat, start;
    re_elem_t e;
    span = comb_span(cfg_mirror.comb_code);
    rbs  = (cfg_mirror.num_rb == 0) ? 1 : cfg_mirror.num_rb;
    nsym = (cfg_mirror.num_symbols == 0) ? 1 : cfg_mirror.num_symbols;
    per_symbol = (12 / span) * rbs;
    // first element of a symbol restarts on the rotated comb
    if (sym_elem == 0) begin
      start = cfg_mirror.re_offset + COMB_ROTATION[cfg_mirror.comb_code][occ_symbol % 12];
      start = start % span + cfg_mirror.ssb_start;
      next_sc = start[12:0];
    end
    k = next_sc;
    sym = cfg_mirror.start_symbol;
    sym = (sym + occ_symbol) & 31;
    flat = sym * cfg_mirror.fft_size + k;
    e.symbol_index = sym[4:0];
    e.subcarrier   = k[11:0];
    e.flat_index   = flat[16:0];
    e.i_value      = qpsk_scale(bits[0]);
    e.q_value      = qpsk_scale(bits[1]);
    e.last         = 1'b0;
    // single wrap at the symbol size
    nxt = k + span;
    if (nxt >= cfg_mirror.fft_size) nxt = nxt - cfg_mirror.fft_size;
    next_sc = nxt[12:0];
    if (sym_elem + 1 >= per_symbol) begin
      sym_elem = 0;
      if (occ_symbol + 1 >= nsym) begin
        occ_symbol = '0;
        e.last = 1'b1;
      end else begin
        occ_symbol = occ_symbol + 4'd1;
      end
    end else begin
      sym_elem++;
    end
    expected_elems.push_back(e);
  endtask

  // Sender: presents queued beats, random gaps, holds payload while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_element(seq_bits_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_bits.size() != 0) begin
          in_valid_i <= 1'b1;
          seq_bits_i <= pending_bits.pop_front();
          gap_left = pick_pause(tx_idle_on);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each element against the oldest prediction, random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_elems.size() == 0) begin
          report_error($sformatf("element %0d arrived with none predicted", rx_count));
        end else begin
          want = expected_elems.pop_front();
          if (symbol_index_o !== want.symbol_index)
            report_error($sformatf("element %0d symbol_index %0d, want %0d",
                                   rx_count, symbol_index_o, want.symbol_index));
          if (subcarrier_o !== want.subcarrier)
            report_error($sformatf("element %0d subcarrier %0d, want %0d",
                                   rx_count, subcarrier_o, want.subcarrier));
          if (flat_index_o !== want.flat_index)
            report_error($sformatf("element %0d flat_index %0d, want %0d",
                                   rx_count, flat_index_o, want.flat_index));
          if (i_value_o !== want.i_value)
            report_error($sformatf("element %0d i_value %0d, want %0d",
                                   rx_count, i_value_o, want.i_value));
          if (q_value_o !== want.q_value)
            report_error($sformatf("element %0d q_value %0d, want %0d",
                                   rx_count, q_value_o, want.q_value));
          if (last_o !== want.last)
            report_error($sformatf("element %0d last %0b, want %0b",
                                   rx_count, last_o, want.last));
        end
        rx_count++;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_pause(rx_idle_on);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("prs_comb_resource_mapper_unit verification failed");
      $finish;
    end
  end

  task automatic write_reg(pcrm_pkg::cfg_reg_e idx, logic [14:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  // Full register set, only while nothing is in flight
  task automatic apply_cfg(map_cfg_t c);
    write_reg(pcrm_pkg::REG_COMB_CODE,    15'(c.comb_code));
    write_reg(pcrm_pkg::REG_RE_OFFSET,    15'(c.re_offset));
    write_reg(pcrm_pkg::REG_NUM_RB,       15'(c.num_rb));
    write_reg(pcrm_pkg::REG_START_SYMBOL, 15'(c.start_symbol));
    write_reg(pcrm_pkg::REG_NUM_SYMBOLS,  15'(c.num_symbols));
    write_reg(pcrm_pkg::REG_SSB_START,    15'(c.ssb_start));
    write_reg(pcrm_pkg::REG_FFT_SIZE,     15'(c.fft_size));
    write_reg(pcrm_pkg::REG_AMPLITUDE,    c.amplitude);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_mirror = c;
  endtask

  task automatic push_bits(logic [1:0] bits);
    pending_bits.push_back(bits);
  endtask

  task automatic push_random(int unsigned n);
    repeat (n) pending_bits.push_back(2'($urandom_range(0, 3)));
  endtask

  // Idle: queue empty, last beat taken, every element back, pipeline settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_bits.size() != 0 || in_valid_i || expected_elems.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic map_cfg_t random_cfg();
    map_cfg_t c;
    int unsigned r;
    int unsigned fft;
    int unsigned ssb;
    c.comb_code = 2'($urandom_range(0, 3));
    c.re_offset = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11));
    r = $urandom_range(0, 99);
    if (r < 70)      c.num_rb = 9'($urandom_range(1, 4));
    else if (r < 90) c.num_rb = 9'($urandom_range(5, 30));
    else if (r < 94) c.num_rb = 9'd0;
    else if (r < 98) c.num_rb = 9'd275;
    else             c.num_rb = 9'd511;
    c.start_symbol = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(14, 15))
                                                 : 4'($urandom_range(0, 13));
    r = $urandom_range(0, 99);
    if (r < 60)      c.num_symbols = 4'($urandom_range(1, 3));
    else if (r < 88) c.num_symbols = 4'($urandom_range(4, 12));
    else if (r < 94) c.num_symbols = 4'd0;
    else             c.num_symbols = 4'($urandom_range(13, 15));
    r = $urandom_range(0, 99);
    if (r < 75)      fft = 128 << $urandom_range(0, 5);
    else if (r < 90) fft = $urandom_range(128, 4096);
    else if (r < 96) fft = $urandom_range(0, 8191);
    else             fft = $urandom_range(0, 16);
    c.fft_size = fft[12:0];
    // start low, just under the symbol size to force the wrap, or anywhere up to 4095
    r = $urandom_range(0, 99);
    if (r < 40) ssb = $urandom_range(0, 64);
    else if (r < 80) ssb = (fft > 48) ? fft - $urandom_range(1, 48) : 0;
    else if (r < 95) ssb = $urandom_range(0, 4095);
    else ssb = 4095;
    if (ssb > 4095) ssb = 4095;
    c.ssb_start = ssb[11:0];
    r = $urandom_range(0, 99);
    if (r < 10)      c.amplitude = 15'd0;
    else if (r < 20) c.amplitude = 15'd32767;
    else             c.amplitude = 15'($urandom_range(0, 32767));
    return c;
  endfunction

  initial begin
    map_cfg_t c;
    int unsigned issued;
    int unsigned n;
    int unsigned phase;
    cfg_mirror = '{comb_code: pcrm_pkg::COMB_2, re_offset: 4'd0, num_rb: 9'd24,
                   start_symbol: 4'd0, num_symbols: 4'd1, ssb_start: 12'd0,
                   fft_size: 13'd2048, amplitude: 15'd32767};
    occ_symbol = '0;
    sym_elem   = 0;
    next_sc    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // Reset defaults, every sign combination
    for (int b = 0; b < 4; b++) push_bits(2'(b));
    wait_drained();

    // Comb 12, one RB per symbol, top symbols, base at the top of the grid
    apply_cfg('{comb_code: pcrm_pkg::COMB_12, re_offset: 4'd11, num_rb: 9'd1,
                start_symbol: 4'd13, num_symbols: 4'd12, ssb_start: 12'd4095,
                fft_size: 13'd4096, amplitude: 15'd32767});
    for (int b = 0; b < 6; b++) push_bits(2'(3 - b % 4));
    wait_drained();

    // Zero counts, zero amplitude, wrap across the symbol end
    apply_cfg('{comb_code: pcrm_pkg::COMB_2, re_offset: 4'd0, num_rb: 9'd0,
                start_symbol: 4'd0, num_symbols: 4'd0, ssb_start: 12'd2040,
                fft_size: 13'd2048, amplitude: 15'd0});
    for (int b = 0; b < 7; b++) push_bits(2'(b));
    wait_drained();

    // Zero symbol size, register maxima above the normal ranges
    apply_cfg('{comb_code: pcrm_pkg::COMB_6, re_offset: 4'd15, num_rb: 9'd1,
                start_symbol: 4'd15, num_symbols: 4'd15, ssb_start: 12'd0,
                fft_size: 13'd0, amplitude: 15'd1});
    for (int b = 0; b < 6; b++) push_bits(2'(b + 1));
    wait_drained();

    // Random phases, each with a fresh register set
    phase  = 0;
    issued = 0;
    while (issued < 1430) begin
      c = random_cfg();
      if (phase == 3) c.num_rb = 9'd275;
      if (phase == 7) begin
        c.num_rb   = 9'd511;
        c.fft_size = 13'd8191;
      end
      apply_cfg(c);
      tx_idle_on = (phase % 6 != 5) && (phase % 4 != 1);
      rx_idle_on = (phase % 6 != 5) && (phase % 4 != 2);
      n = $urandom_range(20, 110);
      if (phase % 5 == 2) begin
        // sender holds off until every element is back, then resumes
        push_random(n / 2);
        wait_drained();
        push_random(n - n / 2);
      end else begin
        push_random(n);
      end
      wait_drained();
      issued += n;
      phase++;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("prs_comb_resource_mapper_unit verification clean");
    end else begin
      $display("prs_comb_resource_mapper_unit verification failed");
    end
    $finish;
  end

endmodule
